FILE: hdl/ppsrv_pkg.sv
package ppsrv_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PREEMPT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_NCLASS  = 1'b1;

  localparam logic [4:0] NCLASS_RESET = 5'd4;

  localparam logic FUNC_ARRIVAL = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  typedef enum logic [2:0] {
    STAT_NONE      = 3'd0,
    STAT_STARTED   = 3'd1,
    STAT_QUEUED    = 3'd2,
    STAT_PREEMPTED = 3'd3,
    STAT_COMPLETED = 3'd4,
    STAT_REJECTED  = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PUT,
    ST_POP_RD,
    ST_POP_LD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       preempt_enable;
    logic [4:0] num_classes;
  } cfg_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  job_id;
    logic [4:0]  priority_req;
    logic [15:0] service_time;
  } job_in_t;

  // Job tag kept with every queued or running job; remaining ticks travel beside it.
  typedef struct packed {
    logic [7:0]  id;
    logic [4:0]  cls;
    logic [15:0] seq;
  } job_tag_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] event_job_id;
    logic [7:0] running_job_id;
    logic       server_busy;
  } res_t;

endpackage

FILE: hdl/ppsrv_ram.sv
module ppsrv_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 45
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/ppsrv_order_cmp.sv
module ppsrv_order_cmp (
  input  ppsrv_pkg::job_tag_t a,
  input  ppsrv_pkg::job_tag_t b,
  input  logic [15:0]         now_seq,
  output logic                a_first
);

  import ppsrv_pkg::*;

  logic [15:0] age_a;
  logic [15:0] age_b;

  // Ages are taken modulo 2^16 against the current arrival counter.
  assign age_a = now_seq - a.seq;
  assign age_b = now_seq - b.seq;

  always_comb begin
    if (a.cls != b.cls) begin
      a_first = (a.cls < b.cls);
    end else begin
      a_first = (age_a > age_b);
    end
  end

endmodule

FILE: hdl/ppsrv_core.sv
module ppsrv_core #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ppsrv_pkg::cfg_t                  cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  ppsrv_pkg::job_in_t               in_job,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ppsrv_pkg::res_t                  out_res,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] out_count
);

  import ppsrv_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = CW + 1;
  localparam int EW = $bits(job_tag_t) + TIME_BITS;
  localparam logic [31:0] TIME_MAX = 32'((64'd1 << TIME_BITS) - 64'd1);
  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [CW-1:0] FULL_C = CW'(QUEUE_DEPTH);

  state_t               state_r, state_nxt;
  logic                 busy_r, busy_nxt;
  job_tag_t             run_tag_r, run_tag_nxt;
  logic [TIME_BITS-1:0] run_rem_r, run_rem_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [AW-1:0]        head_r, head_nxt;
  logic [15:0]          seq_r, seq_nxt;
  logic                 out_valid_r, out_valid_nxt;

  job_in_t              job_r, job_nxt;
  job_tag_t             ins_tag_r, ins_tag_nxt;
  logic [TIME_BITS-1:0] ins_rem_r, ins_rem_nxt;
  logic [CW-1:0]        i_r, i_nxt;
  logic [CW-1:0]        j_r, j_nxt;
  logic [CW-1:0]        pos_r, pos_nxt;
  status_t              status_r, status_nxt;
  logic [7:0]           ev_r, ev_nxt;
  res_t                 out_res_r, out_res_nxt;
  logic [CW-1:0]        out_count_r, out_count_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [EW-1:0]        ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [EW-1:0]        ram_rdata;
  job_tag_t             rd_tag;
  logic [TIME_BITS-1:0] rd_rem;

  job_tag_t             cmp_a;
  job_tag_t             cmp_b;
  logic                 a_first;

  job_tag_t             new_tag;
  logic [TIME_BITS-1:0] new_rem;
  logic [15:0]          svc_eff;
  logic [31:0]          svc_sat;
  logic                 class_bad;

  // Queue positions are logical offsets from the head of a circular buffer.
  function automatic logic [AW-1:0] phys(input logic [CW-1:0] idx);
    logic [PW-1:0] sum;
    sum = PW'(head_r) + PW'(idx);
    if (sum >= PW'(QUEUE_DEPTH)) begin
      sum = sum - PW'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  ppsrv_ram #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH(EW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  ppsrv_order_cmp u_cmp (
    .a      (cmp_a),
    .b      (cmp_b),
    .now_seq(seq_r),
    .a_first(a_first)
  );

  assign rd_tag = ram_rdata[EW-1:TIME_BITS];
  assign rd_rem = ram_rdata[TIME_BITS-1:0];

  assign svc_eff   = (job_r.service_time == 16'd0) ? 16'd1 : job_r.service_time;
  assign svc_sat   = ({16'd0, svc_eff} > TIME_MAX) ? TIME_MAX : {16'd0, svc_eff};
  assign new_rem   = svc_sat[TIME_BITS-1:0];
  assign new_tag   = '{id: job_r.job_id, cls: job_r.priority_req, seq: seq_r};
  assign class_bad = (job_r.priority_req == 5'd0) || (job_r.priority_req > cfg.num_classes);

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_count = out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      run_tag_r   <= '0;
      run_rem_r   <= '0;
      count_r     <= '0;
      head_r      <= '0;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      run_tag_r   <= run_tag_nxt;
      run_rem_r   <= run_rem_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r       <= job_nxt;
    ins_tag_r   <= ins_tag_nxt;
    ins_rem_r   <= ins_rem_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    pos_r       <= pos_nxt;
    status_r    <= status_nxt;
    ev_r        <= ev_nxt;
    out_res_r   <= out_res_nxt;
    out_count_r <= out_count_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    busy_nxt      = busy_r;
    run_tag_nxt   = run_tag_r;
    run_rem_nxt   = run_rem_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    seq_nxt       = seq_r;
    out_valid_nxt = out_valid_r;
    job_nxt       = job_r;
    ins_tag_nxt   = ins_tag_r;
    ins_rem_nxt   = ins_rem_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    pos_nxt       = pos_r;
    status_nxt    = status_r;
    ev_nxt        = ev_r;
    out_res_nxt   = out_res_r;
    out_count_nxt = out_count_r;

    ram_we    = 1'b0;
    ram_waddr = phys(pos_r);
    ram_wdata = {ins_tag_r, ins_rem_r};
    ram_raddr = phys(i_r);
    cmp_a     = ins_tag_r;
    cmp_b     = rd_tag;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          job_nxt   = in_job;
          state_nxt = ST_EVAL;
        end
      end

      ST_EVAL: begin
        status_nxt = STAT_NONE;
        ev_nxt     = 8'd0;
        state_nxt  = ST_DONE;
        // A fresh arrival is never older than the running job, so the order
        // compare reduces to a strictly better class here.
        cmp_a      = new_tag;
        cmp_b      = run_tag_r;
        if (job_r.func == FUNC_ARRIVAL) begin
          ev_nxt = job_r.job_id;
          if (class_bad) begin
            status_nxt = STAT_REJECTED;
          end else if (!busy_r) begin
            run_tag_nxt = new_tag;
            run_rem_nxt = new_rem;
            busy_nxt    = 1'b1;
            status_nxt  = STAT_STARTED;
            seq_nxt     = seq_r + 16'd1;
          end else if (count_r == FULL_C) begin
            status_nxt = STAT_REJECTED;
          end else if (cfg.preempt_enable && a_first) begin
            ev_nxt      = run_tag_r.id;
            ins_tag_nxt = run_tag_r;
            ins_rem_nxt = run_rem_r;
            run_tag_nxt = new_tag;
            run_rem_nxt = new_rem;
            status_nxt  = STAT_PREEMPTED;
            i_nxt       = '0;
            state_nxt   = ST_SCAN_RD;
          end else begin
            ins_tag_nxt = new_tag;
            ins_rem_nxt = new_rem;
            status_nxt  = STAT_QUEUED;
            i_nxt       = '0;
            state_nxt   = ST_SCAN_RD;
          end
        end else if (busy_r) begin
          if (run_rem_r <= TIME_BITS'(1)) begin
            status_nxt = STAT_COMPLETED;
            ev_nxt     = run_tag_r.id;
            if (count_r != '0) begin
              state_nxt = ST_POP_RD;
            end else begin
              busy_nxt    = 1'b0;
              run_tag_nxt = '0;
              run_rem_nxt = '0;
            end
          end else begin
            run_rem_nxt = run_rem_r - TIME_BITS'(1);
          end
        end
      end

      ST_SCAN_RD: begin
        if (i_r == count_r) begin
          pos_nxt   = i_r;
          j_nxt     = count_r;
          state_nxt = ST_SHIFT_RD;
        end else begin
          state_nxt = ST_SCAN_CMP;
        end
      end

      ST_SCAN_CMP: begin
        if (a_first) begin
          pos_nxt   = i_r;
          j_nxt     = count_r;
          state_nxt = ST_SHIFT_RD;
        end else begin
          i_nxt     = i_r + ONE_C;
          state_nxt = ST_SCAN_RD;
        end
      end

      ST_SHIFT_RD: begin
        ram_raddr = phys(j_r - ONE_C);
        if (j_r == pos_r) begin
          state_nxt = ST_PUT;
        end else begin
          state_nxt = ST_SHIFT_WR;
        end
      end

      ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = phys(j_r);
        ram_wdata = ram_rdata;
        j_nxt     = j_r - ONE_C;
        state_nxt = ST_SHIFT_RD;
      end

      ST_PUT: begin
        ram_we    = 1'b1;
        count_nxt = count_r + ONE_C;
        seq_nxt   = seq_r + 16'd1;
        state_nxt = ST_DONE;
      end

      ST_POP_RD: begin
        ram_raddr = head_r;
        state_nxt = ST_POP_LD;
      end

      ST_POP_LD: begin
        run_tag_nxt = rd_tag;
        run_rem_nxt = rd_rem;
        head_nxt    = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + AW'(1);
        count_nxt   = count_r - ONE_C;
        state_nxt   = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = '{status:         status_r,
                            event_job_id:   ev_r,
                            running_job_id: busy_r ? run_tag_r.id : 8'd0,
                            server_busy:    busy_r};
          out_count_nxt = count_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_C)
    else $error("queue count exceeds depth");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (count_r == '0))
    else $error("jobs waiting while server idle");

  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_EVAL))
    else $error("accepted beat not evaluated");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result posted outside done state");

endmodule

FILE: hdl/preemptive_priority_server_top.sv
// A tick, a rejected arrival or an arrival to an idle server passes from EVAL straight to DONE,
// where its result is registered; a completion that starts a queued job also passes POP_RD and POP_LD.
// An insert into the wait queue grows with the number of jobs waiting, set by the
// sequential scan and shift through the queue memory and the one order comparator.
// One beat is in work at a time; the next is taken once the result is in the output
// register. Reset is synchronous, active low, and clears the count.
module preemptive_priority_server_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [ppsrv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ppsrv_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // job_id[7:0], priority_req[12:8], service_time[28:13], zero fill
  input  logic [31:0]                           in_tdata,
  // func[0]
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // status, event_job_id, running_job_id, server_busy, queue_count, zero fill
  output logic [((20+$clog2(QUEUE_DEPTH+1)+7)/8)*8-1:0] out_tdata
);

  import ppsrv_pkg::*;

  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_W = ((20 + CW + 7) / 8) * 8;

  cfg_t          cfg_r;
  job_in_t       in_job;
  res_t          res;
  logic [CW-1:0] res_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.preempt_enable <= 1'b0;
      cfg_r.num_classes    <= NCLASS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_PREEMPT: cfg_r.preempt_enable <= cfg_wdata[0];
        CFG_IDX_NCLASS:  cfg_r.num_classes    <= cfg_wdata[4:0];
      endcase
    end
  end

  assign in_job = '{func:         in_tuser,
                    job_id:       in_tdata[7:0],
                    priority_req: in_tdata[12:8],
                    service_time: in_tdata[28:13]};

  ppsrv_core #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TIME_BITS  (TIME_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_job   (in_job),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (res),
    .out_count(res_count)
  );

  assign out_tdata = OUT_W'({res_count, res.server_busy, res.running_job_id,
                             res.event_job_id, res.status});

endmodule
